// File: rtl/ch_pkg.sv
// Shared types, cell operation codes and point ordering for the convex hull block.
package ch_pkg;

    localparam int MaxPointsDef = 64;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
    } pt_t;

    typedef struct packed {
        logic valid;
        pt_t  pt;
    } cell_t;

    typedef enum logic [1:0] {
        SORT_HOLD,
        SORT_INSERT,
        SORT_POP
    } sort_op_t;

    typedef enum logic [1:0] {
        STK_HOLD,
        STK_PUSH,
        STK_POP,
        STK_CLEAR
    } stk_op_t;

    // lexicographic order: x first, then y
    function automatic logic pt_before(pt_t a, pt_t b);
        logic r;
        r = (a.x < b.x) || ((a.x == b.x) && (a.y < b.y));
        return r;
    endfunction

endpackage

// File: rtl/ch_sort_cell.sv
// One cell of the insertion sorting chain: keeps one point, inserts or shifts toward cell 0.
module ch_sort_cell
    import ch_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  sort_op_t op,
    input  pt_t      new_pt,
    input  cell_t    prev_cell,
    input  logic     prev_lt,
    input  cell_t    next_cell,
    output cell_t    slot,
    output logic     lt
);

    logic valid_reg;
    logic valid_next;
    pt_t  pt_reg;
    pt_t  pt_next;
    logic take;

    assign lt   = valid_reg && pt_before(new_pt, pt_reg);
    assign take = !valid_reg || pt_before(new_pt, pt_reg);
    assign slot = '{valid: valid_reg, pt: pt_reg};

    always_comb
    begin
        valid_next = valid_reg;
        pt_next    = pt_reg;
        case (op)
            SORT_INSERT:
            begin
                if (take)
                begin
                    pt_next    = prev_lt ? prev_cell.pt : new_pt;
                    valid_next = valid_reg | prev_cell.valid;
                end
            end
            SORT_POP:
            begin
                pt_next    = next_cell.pt;
                valid_next = next_cell.valid;
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pt_reg <= pt_next;
    end

endmodule

// File: rtl/ch_stack_cell.sv
// One cell of a shift stack: push moves words deeper, pop moves them toward the top.
module ch_stack_cell
    import ch_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  stk_op_t op,
    input  cell_t   shallow_cell,
    input  cell_t   deep_cell,
    output cell_t   slot
);

    logic valid_reg;
    logic valid_next;
    pt_t  pt_reg;
    pt_t  pt_next;

    assign slot = '{valid: valid_reg, pt: pt_reg};

    always_comb
    begin
        valid_next = valid_reg;
        pt_next    = pt_reg;
        case (op)
            STK_PUSH:
            begin
                valid_next = shallow_cell.valid;
                pt_next    = shallow_cell.pt;
            end
            STK_POP:
            begin
                valid_next = deep_cell.valid;
                pt_next    = deep_cell.pt;
            end
            STK_CLEAR:
            begin
                valid_next = 1'b0;
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pt_reg <= pt_next;
    end

endmodule

// File: rtl/convex_hull_monotone_chain.sv
// Top level of the monotone chain convex hull engine.
//
// Input channel (point_x, point_y, last_point; in_valid/in_ready) takes one
// point word per cycle; each is inserted into a sorted chain of cells on the
// cycle it is taken. Words past MAX_POINTS are dropped. The word with
// last_point set closes the set and in_ready drops until all hull vertices
// have been delivered.
// After the last point the block walks the sorted points forward and then
// backward; with fewer than three points the backward walk is skipped. Each
// point is fetched, then pushed directly or after a cross product check, and
// every stack pop leads back to the test (one multiply stage, one compare stage
// on the pair of 17x17 products). A turn step lies between the lower and upper
// chain, and a further step starts emission. Emission then shifts the hull
// stack (2*MAX_POINTS cells) until its oldest word reaches the output cell,
// then gives one vertex per cycle while out_ready is high. A clear step follows.
// Output channel (vertex_x, vertex_y, last_vertex; out_valid/out_ready)
// holds its word while out_ready is low; the engine simply waits.
// Reset empties the chains and returns to accepting points.
module convex_hull_monotone_chain
    import ch_pkg::*;
#(
    parameter int MAX_POINTS = MaxPointsDef
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] point_x,
    input  logic signed [15:0] point_y,
    input  logic               last_point,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] vertex_x,
    output logic signed [15:0] vertex_y,
    output logic               last_vertex
);

    localparam int Depth = 2 * MAX_POINTS;
    localparam int CntW  = $clog2(MAX_POINTS + 1);
    localparam int TopW  = $clog2(Depth + 1);

    typedef enum logic [5:0] {
        S_LOAD  = 6'b000001,
        S_FETCH = 6'b000010,
        S_TEST  = 6'b000100,
        S_CMP   = 6'b001000,
        S_EMIT  = 6'b010000,
        S_CLEAR = 6'b100000
    } state_t;

    state_t             state_reg, state_next;
    logic [CntW-1:0]    count_reg, count_next;
    logic [CntW-1:0]    n_reg, n_next;
    logic [CntW-1:0]    remain_reg, remain_next;
    logic [TopW-1:0]    top_reg, top_next;
    logic [TopW-1:0]    floor_reg, floor_next;
    logic [TopW-1:0]    emit_reg, emit_next;
    logic [TopW-1:0]    vcount_reg, vcount_next;
    logic               rev_reg, rev_next;
    logic               small_reg, small_next;
    pt_t                cur_reg, cur_next;
    logic signed [33:0] prod_a_reg, prod_a_next;
    logic signed [33:0] prod_b_reg, prod_b_next;

    sort_op_t sort_op;
    stk_op_t  rev_op;
    stk_op_t  hull_op;
    pt_t      in_pt;
    cell_t    hull_in;

    cell_t sort_cells [MAX_POINTS];
    logic  sort_lt    [MAX_POINTS];
    cell_t rev_cells  [MAX_POINTS];
    cell_t hull_cells [Depth];

    logic               in_acc;
    logic               out_acc;
    logic signed [16:0] ax, ay, bx, by;

    assign in_pt   = '{x: point_x, y: point_y};
    assign in_ready = (state_reg == S_LOAD);
    assign in_acc   = in_valid && in_ready;
    assign out_valid = (state_reg == S_EMIT) && hull_cells[Depth-1].valid;
    assign out_acc   = out_valid && out_ready;
    assign vertex_x  = hull_cells[Depth-1].pt.x;
    assign vertex_y  = hull_cells[Depth-1].pt.y;
    assign last_vertex = (emit_reg == vcount_reg - TopW'(1));
    assign hull_in = (state_reg == S_EMIT) ? cell_t'('0) : cell_t'{valid: 1'b1, pt: cur_reg};

    assign ax = {hull_cells[0].pt.x[15], hull_cells[0].pt.x}
              - {hull_cells[1].pt.x[15], hull_cells[1].pt.x};
    assign ay = {hull_cells[0].pt.y[15], hull_cells[0].pt.y}
              - {hull_cells[1].pt.y[15], hull_cells[1].pt.y};
    assign bx = {cur_reg.x[15], cur_reg.x} - {hull_cells[1].pt.x[15], hull_cells[1].pt.x};
    assign by = {cur_reg.y[15], cur_reg.y} - {hull_cells[1].pt.y[15], hull_cells[1].pt.y};

    genvar gi;
    generate
        for (gi = 0; gi < MAX_POINTS; gi++)
        begin : g_sort
            cell_t prev_c;
            logic  prev_l;
            cell_t next_c;
            if (gi == 0)
            begin : g_first
                assign prev_c = '{valid: 1'b1, pt: in_pt};
                assign prev_l = 1'b0;
            end
            else
            begin : g_mid
                assign prev_c = sort_cells[gi-1];
                assign prev_l = sort_lt[gi-1];
            end
            if (gi == MAX_POINTS - 1)
            begin : g_end
                assign next_c = '0;
            end
            else
            begin : g_inner
                assign next_c = sort_cells[gi+1];
            end
            ch_sort_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .op        (sort_op),
                .new_pt    (in_pt),
                .prev_cell (prev_c),
                .prev_lt   (prev_l),
                .next_cell (next_c),
                .slot      (sort_cells[gi]),
                .lt        (sort_lt[gi])
            );
        end

        for (gi = 0; gi < MAX_POINTS; gi++)
        begin : g_rev
            cell_t sh_c;
            cell_t dp_c;
            if (gi == 0)
            begin : g_first
                assign sh_c = '{valid: 1'b1, pt: sort_cells[0].pt};
            end
            else
            begin : g_mid
                assign sh_c = rev_cells[gi-1];
            end
            if (gi == MAX_POINTS - 1)
            begin : g_end
                assign dp_c = '0;
            end
            else
            begin : g_inner
                assign dp_c = rev_cells[gi+1];
            end
            ch_stack_cell u_cell (
                .clk          (clk),
                .rst_n        (rst_n),
                .op           (rev_op),
                .shallow_cell (sh_c),
                .deep_cell    (dp_c),
                .slot         (rev_cells[gi])
            );
        end

        for (gi = 0; gi < Depth; gi++)
        begin : g_hull
            cell_t sh_c;
            cell_t dp_c;
            if (gi == 0)
            begin : g_first
                assign sh_c = hull_in;
            end
            else
            begin : g_mid
                assign sh_c = hull_cells[gi-1];
            end
            if (gi == Depth - 1)
            begin : g_end
                assign dp_c = '0;
            end
            else
            begin : g_inner
                assign dp_c = hull_cells[gi+1];
            end
            ch_stack_cell u_cell (
                .clk          (clk),
                .rst_n        (rst_n),
                .op           (hull_op),
                .shallow_cell (sh_c),
                .deep_cell    (dp_c),
                .slot         (hull_cells[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        n_next      = n_reg;
        remain_next = remain_reg;
        top_next    = top_reg;
        floor_next  = floor_reg;
        emit_next   = emit_reg;
        vcount_next = vcount_reg;
        rev_next    = rev_reg;
        small_next  = small_reg;
        cur_next    = cur_reg;
        prod_a_next = prod_a_reg;
        prod_b_next = prod_b_reg;
        sort_op     = SORT_HOLD;
        rev_op      = STK_HOLD;
        hull_op     = STK_HOLD;
        case (state_reg)
            S_LOAD:
            begin
                if (in_acc)
                begin
                    if (count_reg < CntW'(MAX_POINTS))
                    begin
                        sort_op    = SORT_INSERT;
                        count_next = count_reg + CntW'(1);
                    end
                    if (last_point)
                    begin
                        n_next      = count_next;
                        remain_next = count_next;
                        small_next  = (count_next < CntW'(3));
                        count_next  = '0;
                        rev_next    = 1'b0;
                        top_next    = '0;
                        floor_next  = TopW'(2);
                        state_next  = S_FETCH;
                    end
                end
            end
            S_FETCH:
            begin
                if (remain_reg != '0)
                begin
                    remain_next = remain_reg - CntW'(1);
                    state_next  = S_TEST;
                    if (!rev_reg)
                    begin
                        cur_next = sort_cells[0].pt;
                        sort_op  = SORT_POP;
                        rev_op   = STK_PUSH;
                    end
                    else
                    begin
                        cur_next = rev_cells[0].pt;
                        rev_op   = STK_POP;
                    end
                end
                else if (!rev_reg && !small_reg)
                begin
                    // drop the rightmost point, it already closes the lower chain
                    rev_next    = 1'b1;
                    floor_next  = top_reg + TopW'(1);
                    rev_op      = STK_POP;
                    remain_next = n_reg - CntW'(1);
                end
                else
                begin
                    vcount_next = small_reg ? top_reg : top_reg - TopW'(1);
                    emit_next   = '0;
                    state_next  = S_EMIT;
                end
            end
            S_TEST:
            begin
                if (!small_reg && (top_reg >= floor_reg) && (top_reg >= TopW'(2)))
                begin
                    prod_a_next = ax * by;
                    prod_b_next = ay * bx;
                    state_next  = S_CMP;
                end
                else
                begin
                    hull_op    = STK_PUSH;
                    top_next   = top_reg + TopW'(1);
                    state_next = S_FETCH;
                end
            end
            S_CMP:
            begin
                if (prod_a_reg <= prod_b_reg)
                begin
                    hull_op    = STK_POP;
                    top_next   = top_reg - TopW'(1);
                    state_next = S_TEST;
                end
                else
                begin
                    hull_op    = STK_PUSH;
                    top_next   = top_reg + TopW'(1);
                    state_next = S_FETCH;
                end
            end
            S_EMIT:
            begin
                if (!hull_cells[Depth-1].valid)
                begin
                    hull_op = STK_PUSH;
                end
                else if (out_acc)
                begin
                    hull_op   = STK_PUSH;
                    emit_next = emit_reg + TopW'(1);
                    if (last_vertex)
                    begin
                        state_next = S_CLEAR;
                    end
                end
            end
            S_CLEAR:
            begin
                hull_op    = STK_CLEAR;
                top_next   = '0;
                state_next = S_LOAD;
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_LOAD;
            count_reg  <= '0;
            n_reg      <= '0;
            remain_reg <= '0;
            top_reg    <= '0;
            floor_reg  <= '0;
            emit_reg   <= '0;
            vcount_reg <= '0;
            rev_reg    <= 1'b0;
            small_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            n_reg      <= n_next;
            remain_reg <= remain_next;
            top_reg    <= top_next;
            floor_reg  <= floor_next;
            emit_reg   <= emit_next;
            vcount_reg <= vcount_next;
            rev_reg    <= rev_next;
            small_reg  <= small_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg    <= cur_next;
        prod_a_reg <= prod_a_next;
        prod_b_reg <= prod_b_next;
    end

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("output word while loading points");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (out_acc && last_vertex) |=> !out_valid)
        else $error("word offered after last vertex");

    a_top_bound: assert property (@(posedge clk) disable iff (!rst_n)
        top_reg <= TopW'(Depth - 1))
        else $error("hull stack overflow");

    a_cmp_after_test: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP) |-> ($past(state_reg) == S_TEST))
        else $error("compare without product stage");

endmodule
